// ===== hw/rtl/dvtm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dvtm_pkg
// Shared types, constants and helpers for the drum voice tick mixer.
// ----------------------------------------------------------------------------
package dvtm_pkg;

    localparam int PATTERN_STEPS_DEF = 32;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int LEVEL_W    = 16;
    localparam int MIX_W      = 18;
    localparam int SAMPLE_W   = 9;

    localparam logic [CFG_ADDR_W-1:0] CFG_KICK_STEPS        = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SNARE_STEPS       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_HIHAT_STEPS       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_KICK_ENV_START    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_KICK_PERIOD_START = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_SNARE_ENV_START   = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_HIHAT_ENV_START   = 3'd6;

    localparam logic [31:0]        KICK_STEPS_RST        = 32'd4112;
    localparam logic [LEVEL_W-1:0] ENV_START_RST         = 16'd1020;
    localparam logic [LEVEL_W-1:0] KICK_PERIOD_START_RST = 16'd60;
    localparam logic [LEVEL_W-1:0] KICK_HALF_PERIOD_RST  = 16'd120;
    localparam logic [LEVEL_W-1:0] KICK_PERIOD_MAX       = 16'd180;

    localparam logic [15:0] NOISE_TAPS = 16'hB400;
    localparam logic [15:0] NOISE_SEED = 16'hACE1;

    localparam logic [LEVEL_W-1:0] KICK_DECAY  = 16'd4;
    localparam logic [LEVEL_W-1:0] SNARE_DECAY = 16'd8;
    localparam logic [LEVEL_W-1:0] HIHAT_DECAY = 16'd20;

    localparam logic signed [MIX_W-1:0] MIX_MIN = -18'sd256;
    localparam logic signed [MIX_W-1:0] MIX_MAX = 18'sd255;

    typedef struct packed {
        logic [31:0]        kick_steps;
        logic [31:0]        snare_steps;
        logic [31:0]        hihat_steps;
        logic [LEVEL_W-1:0] kick_env_start;
        logic [LEVEL_W-1:0] kick_period_start;
        logic [LEVEL_W-1:0] snare_env_start;
        logic [LEVEL_W-1:0] hihat_env_start;
    } cfg_t;

    function automatic logic [LEVEL_W-1:0] decay(input logic [LEVEL_W-1:0] level,
                                                 input logic [LEVEL_W-1:0] amount);
        return (level > amount) ? (level - amount) : '0;
    endfunction

    function automatic logic signed [MIX_W-1:0] signed_amp(input logic [LEVEL_W-1:0] level,
                                                           input logic negative);
        logic signed [MIX_W-1:0] amp;
        amp = $signed({{(MIX_W-LEVEL_W+2){1'b0}}, level[LEVEL_W-1:2]});
        return negative ? -amp : amp;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/dvtm_cfg_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dvtm_cfg_regs
// Configuration register file for the patterns and voice start values.
// ----------------------------------------------------------------------------
module dvtm_cfg_regs
    import dvtm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  wr_en,
    input  wire logic [CFG_ADDR_W-1:0] wr_addr,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_addr)
                CFG_KICK_STEPS:        cfg_next.kick_steps        = wr_data;
                CFG_SNARE_STEPS:       cfg_next.snare_steps       = wr_data;
                CFG_HIHAT_STEPS:       cfg_next.hihat_steps       = wr_data;
                CFG_KICK_ENV_START:    cfg_next.kick_env_start    = wr_data[LEVEL_W-1:0];
                CFG_KICK_PERIOD_START: cfg_next.kick_period_start = wr_data[LEVEL_W-1:0];
                CFG_SNARE_ENV_START:   cfg_next.snare_env_start   = wr_data[LEVEL_W-1:0];
                CFG_HIHAT_ENV_START:   cfg_next.hihat_env_start   = wr_data[LEVEL_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kick_steps        <= KICK_STEPS_RST;
            cfg_reg.snare_steps       <= '0;
            cfg_reg.hihat_steps       <= '0;
            cfg_reg.kick_env_start    <= ENV_START_RST;
            cfg_reg.kick_period_start <= KICK_PERIOD_START_RST;
            cfg_reg.snare_env_start   <= ENV_START_RST;
            cfg_reg.hihat_env_start   <= ENV_START_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/dvtm_voice_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dvtm_voice_core
// Voice state, noise generator and mixer; advances one tick per fire.
// ----------------------------------------------------------------------------
module dvtm_voice_core
    import dvtm_pkg::*;
#(
    parameter int PATTERN_STEPS = PATTERN_STEPS_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       fire,
    input  wire logic                       step_advanced,
    input  wire logic [4:0]                 step_num,
    input  wire cfg_t                       cfg,
    output logic signed [SAMPLE_W-1:0]      mixed_sample
);

    logic [15:0]        noise_reg, noise_next;
    logic [LEVEL_W-1:0] kick_level_reg, kick_level_next;
    logic [LEVEL_W-1:0] snare_level_reg, snare_level_next;
    logic [LEVEL_W-1:0] hihat_level_reg, hihat_level_next;
    logic [LEVEL_W-1:0] kick_half_period_reg, kick_half_period_next;
    logic [LEVEL_W-1:0] kick_countdown_reg, kick_countdown_next;
    logic               kick_negative_reg, kick_negative_next;

    logic                    step_hit;
    logic                    kick_trig, snare_trig, hihat_trig;
    logic [LEVEL_W-1:0]      kick_lvl, snare_lvl, hihat_lvl;
    logic [LEVEL_W-1:0]      kick_hp, kick_cd;
    logic                    kick_neg;
    logic signed [MIX_W-1:0] mix;

    assign step_hit   = step_advanced && (32'(step_num) < 32'(PATTERN_STEPS));
    assign kick_trig  = step_hit && cfg.kick_steps[step_num];
    assign snare_trig = step_hit && cfg.snare_steps[step_num];
    assign hihat_trig = step_hit && cfg.hihat_steps[step_num];

    always_comb begin
        kick_lvl  = kick_trig  ? cfg.kick_env_start    : kick_level_reg;
        kick_hp   = kick_trig  ? cfg.kick_period_start : kick_half_period_reg;
        kick_cd   = kick_trig  ? cfg.kick_period_start : kick_countdown_reg;
        kick_neg  = kick_trig  ? 1'b0                  : kick_negative_reg;
        snare_lvl = snare_trig ? cfg.snare_env_start   : snare_level_reg;
        hihat_lvl = hihat_trig ? cfg.hihat_env_start   : hihat_level_reg;

        noise_next = {1'b0, noise_reg[15:1]} ^ (noise_reg[0] ? NOISE_TAPS : 16'h0000);

        kick_half_period_next = kick_hp;
        kick_countdown_next   = kick_cd;
        kick_negative_next    = kick_neg;
        kick_level_next       = kick_lvl;
        snare_level_next      = snare_lvl;
        hihat_level_next      = hihat_lvl;
        mix                   = '0;

        if (kick_lvl != '0) begin
            if (kick_cd == '0) begin
                kick_countdown_next = kick_hp;
                kick_negative_next  = !kick_neg;
                if (kick_hp < KICK_PERIOD_MAX) begin
                    kick_half_period_next = kick_hp + 16'd1;
                end
            end else begin
                kick_countdown_next = kick_cd - 16'd1;
            end
            mix             = signed_amp(kick_lvl, kick_negative_next);
            kick_level_next = decay(kick_lvl, KICK_DECAY);
        end

        if (snare_lvl != '0) begin
            mix              = mix + signed_amp(snare_lvl, !noise_next[0]);
            snare_level_next = decay(snare_lvl, SNARE_DECAY);
        end

        if (hihat_lvl != '0) begin
            mix              = mix + signed_amp(hihat_lvl, !noise_next[0]);
            hihat_level_next = decay(hihat_lvl, HIHAT_DECAY);
        end

        if (mix > MIX_MAX) begin
            mix = MIX_MAX;
        end else if (mix < MIX_MIN) begin
            mix = MIX_MIN;
        end
        mixed_sample = mix[SAMPLE_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            noise_reg            <= NOISE_SEED;
            kick_level_reg       <= '0;
            snare_level_reg      <= '0;
            hihat_level_reg      <= '0;
            kick_half_period_reg <= KICK_HALF_PERIOD_RST;
            kick_countdown_reg   <= '0;
            kick_negative_reg    <= 1'b0;
        end else if (fire) begin
            noise_reg            <= noise_next;
            kick_level_reg       <= kick_level_next;
            snare_level_reg      <= snare_level_next;
            hihat_level_reg      <= hihat_level_next;
            kick_half_period_reg <= kick_half_period_next;
            kick_countdown_reg   <= kick_countdown_next;
            kick_negative_reg    <= kick_negative_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/drum_voice_tick_mixer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// drum_voice_tick_mixer
// Per-tick drum synthesizer: kick, snare and hi-hat voices mixed to a PWM duty.
// ----------------------------------------------------------------------------
// Channel   Direction  Beat
// s_*       in         one audio tick: step_advanced, step_num
// m_*       out        one sample: pwm_duty, mixed_sample
// cfg_*     in         register write: index and data
//
// One tick per cycle is sustained while the output is not stalled; a tick's
// sample is presented when it reaches the result register from the input register.
// The voice update is a single pass of logic between those two registers.
// A stalled output holds its sample and the input register; no beat is lost.
// Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module drum_voice_tick_mixer
    import dvtm_pkg::*;
#(
    parameter int PATTERN_STEPS = PATTERN_STEPS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // step_advanced, step_num, pad
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [23:0]                m_tdata,   // pwm_duty, mixed_sample, pad
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;

    logic                       in_valid_reg;
    logic                       in_adv_reg;
    logic [4:0]                 in_step_reg;
    logic                       out_valid_reg;
    logic [SAMPLE_W-1:0]        out_mix_reg;
    logic                       out_free;
    logic                       fire;
    logic signed [SAMPLE_W-1:0] mixed_sample;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;

    dvtm_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cfg_valid && cfg_ready),
        .wr_addr (cfg_addr),
        .wr_data (cfg_data),
        .cfg     (cfg)
    );

    dvtm_voice_core #(
        .PATTERN_STEPS (PATTERN_STEPS)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (fire),
        .step_advanced (in_adv_reg),
        .step_num      (in_step_reg),
        .cfg           (cfg),
        .mixed_sample  (mixed_sample)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_adv_reg  <= s_tdata[0];
            in_step_reg <= s_tdata[5:1];
        end
        if (fire) begin
            out_mix_reg <= mixed_sample;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_mix_reg, ~out_mix_reg[SAMPLE_W-1], out_mix_reg[SAMPLE_W-2:0]};

endmodule
`default_nettype wire

// ===== tb/drum_voice_tick_mixer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drum_voice_tick_mixer_tb
// Self-checking bench for the drum voice tick mixer. A short table of
// directed ticks runs under the reset settings, followed by several phases
// that each rewrite every register and then send sequencer-like and random
// ticks. A local model of the voices predicts each output sample, and every
// output beat is compared field by field with the oldest prediction. Both
// stream sides idle and stall at random, with a different mix per phase.
// ----------------------------------------------------------------------------
module drum_voice_tick_mixer_tb
    import dvtm_pkg::*;
();

    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 3'd7;
    localparam int IDLE_NONE   = 0;
    localparam int IDLE_SEND   = 1;
    localparam int IDLE_RECV   = 2;
    localparam int IDLE_BOTH   = 3;
    localparam int PHASES      = 8;
    localparam int PHASE_TICKS = 75;

    typedef struct packed {
        logic [8:0] duty;
        logic [8:0] level;
    } tick_out_t;

    typedef struct packed {
        logic       adv;
        logic [4:0] idx;
        logic       typed;
        tick_out_t  out;
    } tick_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;   // step_advanced, step_num, pad
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;   // pwm_duty, mixed_sample, pad
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_data;

    cfg_t        voice_cfg;
    logic [15:0] noise_lfsr;
    logic [15:0] kick_lvl, snare_lvl, hihat_lvl;
    logic [15:0] kick_hp, kick_cd;
    logic        kick_neg;

    tick_out_t expected_samples[$];
    int        idle_mode;
    int        errors;

    tick_row_t directed_rows [20] = '{
        '{1'b0, 5'd0,  1'b1, '{9'd256, 9'd0}},
        '{1'b1, 5'd31, 1'b1, '{9'd256, 9'd0}},
        '{1'b1, 5'd0,  1'b1, '{9'd256, 9'd0}},
        '{1'b1, 5'd4,  1'b1, '{9'd511, 9'd255}},
        '{1'b0, 5'd31, 1'b0, '{9'd0, 9'd0}},
        '{1'b0, 5'd12, 1'b0, '{9'd0, 9'd0}},
        '{1'b1, 5'd5,  1'b0, '{9'd0, 9'd0}},
        '{1'b1, 5'd12, 1'b0, '{9'd0, 9'd0}},
        '{1'b0, 5'd12, 1'b0, '{9'd0, 9'd0}},
        '{1'b1, 5'd21, 1'b0, '{9'd0, 9'd0}},
        '{1'b1, 5'd10, 1'b0, '{9'd0, 9'd0}},
        '{1'b1, 5'd4,  1'b0, '{9'd0, 9'd0}},
        '{1'b1, 5'd4,  1'b0, '{9'd0, 9'd0}},
        '{1'b0, 5'd4,  1'b0, '{9'd0, 9'd0}},
        '{1'b1, 5'd16, 1'b0, '{9'd0, 9'd0}},
        '{1'b1, 5'd31, 1'b0, '{9'd0, 9'd0}},
        '{1'b0, 5'd0,  1'b0, '{9'd0, 9'd0}},
        '{1'b1, 5'd12, 1'b0, '{9'd0, 9'd0}},
        '{1'b0, 5'd21, 1'b0, '{9'd0, 9'd0}},
        '{1'b0, 5'd10, 1'b0, '{9'd0, 9'd0}}
    };

    drum_voice_tick_mixer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic bit roll(input int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic tick_out_t mix_tick(input logic adv, input logic [4:0] idx);
        int        mix;
        int        amp;
        tick_out_t res;
        mix = 0;
        if (adv && idx < PATTERN_STEPS_DEF) begin
            if (voice_cfg.kick_steps[idx]) begin
                kick_lvl = voice_cfg.kick_env_start;
                kick_hp  = voice_cfg.kick_period_start;
                kick_cd  = voice_cfg.kick_period_start;
                kick_neg = 1'b0;
            end
            if (voice_cfg.snare_steps[idx]) begin
                snare_lvl = voice_cfg.snare_env_start;
            end
            if (voice_cfg.hihat_steps[idx]) begin
                hihat_lvl = voice_cfg.hihat_env_start;
            end
        end
        noise_lfsr = (noise_lfsr >> 1) ^ (noise_lfsr[0] ? NOISE_TAPS : 16'h0000);
        if (kick_lvl != 0) begin
            if (kick_cd == 0) begin
                kick_cd  = kick_hp;
                kick_neg = ~kick_neg;
                if (kick_hp < KICK_PERIOD_MAX) begin
                    kick_hp = kick_hp + 16'd1;
                end
            end else begin
                kick_cd = kick_cd - 16'd1;
            end
            amp = int'(kick_lvl >> 2);
            mix += kick_neg ? -amp : amp;
            kick_lvl = (kick_lvl > KICK_DECAY) ? kick_lvl - KICK_DECAY : 16'd0;
        end
        if (snare_lvl != 0) begin
            amp = int'(snare_lvl >> 2);
            mix += noise_lfsr[0] ? amp : -amp;
            snare_lvl = (snare_lvl > SNARE_DECAY) ? snare_lvl - SNARE_DECAY : 16'd0;
        end
        if (hihat_lvl != 0) begin
            amp = int'(hihat_lvl >> 2);
            mix += noise_lfsr[0] ? amp : -amp;
            hihat_lvl = (hihat_lvl > HIHAT_DECAY) ? hihat_lvl - HIHAT_DECAY : 16'd0;
        end
        if (mix > 255) begin
            mix = 255;
        end
        if (mix < -256) begin
            mix = -256;
        end
        res.duty  = 9'(mix + 256);
        res.level = 9'(mix);
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
        errors++;
    endtask

    task automatic send_tick(input logic adv, input logic [4:0] idx, input logic typed,
                             input tick_out_t typed_out);
        tick_out_t want;
        while ((idle_mode == IDLE_SEND && roll(62)) || (idle_mode == IDLE_BOTH && roll(38))) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, idx, adv};
        do @(posedge aclk); while (!s_tready);
        want = mix_tick(adv, idx);
        if (typed) begin
            want = typed_out;
        end
        expected_samples.push_back(want);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_KICK_STEPS:        voice_cfg.kick_steps        = val;
            CFG_SNARE_STEPS:       voice_cfg.snare_steps       = val;
            CFG_HIHAT_STEPS:       voice_cfg.hihat_steps       = val;
            CFG_KICK_ENV_START:    voice_cfg.kick_env_start    = val[15:0];
            CFG_KICK_PERIOD_START: voice_cfg.kick_period_start = val[15:0];
            CFG_SNARE_ENV_START:   voice_cfg.snare_env_start   = val[15:0];
            CFG_HIHAT_ENV_START:   voice_cfg.hihat_env_start   = val[15:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input cfg_t c);
        write_reg(CFG_KICK_STEPS, c.kick_steps);
        write_reg(CFG_SNARE_STEPS, c.snare_steps);
        write_reg(CFG_HIHAT_STEPS, c.hihat_steps);
        write_reg(CFG_KICK_ENV_START, {16'h0000, c.kick_env_start});
        write_reg(CFG_KICK_PERIOD_START, {16'($urandom_range(0, 65535)), c.kick_period_start});
        write_reg(CFG_SNARE_ENV_START, {16'h0000, c.snare_env_start});
        write_reg(CFG_HIHAT_ENV_START, {16'hFFFF, c.hihat_env_start});
        write_reg(CFG_UNUSED, $urandom);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (expected_samples.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_env();
        return roll(50) ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 2047));
    endfunction

    always @(posedge aclk) begin : check_samples
        tick_out_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_samples.size() == 0) begin
                report_mismatch("unexpected beat", int'(m_tdata[17:0]), 0);
            end else begin
                want = expected_samples.pop_front();
                if (m_tdata[8:0] !== want.duty) begin
                    report_mismatch("pwm_duty", int'(m_tdata[8:0]), int'(want.duty));
                end
                if (m_tdata[17:9] !== want.level) begin
                    report_mismatch("mixed_sample", int'($signed(m_tdata[17:9])),
                                    int'($signed(want.level)));
                end
            end
        end
        m_tready <= !((idle_mode == IDLE_RECV && roll(62)) || (idle_mode == IDLE_BOTH && roll(38)));
    end

    initial begin
        #5000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        cfg_t       c;
        logic       adv;
        logic [4:0] idx;
        logic [4:0] seq_step;
        int         ticks_left;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        cfg_valid  = 1'b0;
        cfg_addr   = '0;
        cfg_data   = '0;
        aresetn    = 1'b0;
        idle_mode  = IDLE_NONE;
        errors     = 0;
        voice_cfg  = '{KICK_STEPS_RST, 32'd0, 32'd0, ENV_START_RST, KICK_PERIOD_START_RST,
                       ENV_START_RST, ENV_START_RST};
        noise_lfsr = NOISE_SEED;
        kick_lvl   = '0;
        snare_lvl  = '0;
        hihat_lvl  = '0;
        kick_hp    = KICK_HALF_PERIOD_RST;
        kick_cd    = '0;
        kick_neg   = 1'b0;
        seq_step   = '0;
        ticks_left = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_tick(directed_rows[i].adv, directed_rows[i].idx, directed_rows[i].typed,
                      directed_rows[i].out);
        end
        s_tvalid <= 1'b0;

        for (int p = 0; p < PHASES; p++) begin
            wait_drain();
            case (p)
                0: c = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000,
                         16'hFFFF, 16'hFFFF};
                1: c = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF,
                         16'h0000, 16'h0000};
                2: c = '{32'h1111_1111, 32'h0101_0101, 32'h5555_5555, 16'd1020, 16'd180,
                         16'd1020, 16'd1020};
                default: begin
                    c.kick_steps        = roll(50) ? $urandom : ($urandom & $urandom);
                    c.snare_steps       = roll(50) ? $urandom : ($urandom & $urandom);
                    c.hihat_steps       = roll(50) ? $urandom : ($urandom & $urandom);
                    c.kick_env_start    = pick_env();
                    c.kick_period_start = roll(25) ? 16'($urandom_range(0, 65535))
                                                   : 16'($urandom_range(0, 200));
                    c.snare_env_start   = pick_env();
                    c.hihat_env_start   = pick_env();
                end
            endcase
            load_settings(c);
            idle_mode = (p + 1) % 4;
            for (int n = 0; n < PHASE_TICKS; n++) begin
                if (roll(70)) begin
                    if (ticks_left == 0) begin
                        adv        = 1'b1;
                        idx        = seq_step;
                        seq_step   = seq_step + 5'd1;
                        ticks_left = $urandom_range(0, 6);
                    end else begin
                        adv        = 1'b0;
                        idx        = seq_step - 5'd1;
                        ticks_left = ticks_left - 1;
                    end
                end else begin
                    adv = 1'($urandom);
                    idx = 5'($urandom);
                end
                send_tick(adv, idx, 1'b0, '0);
            end
            s_tvalid <= 1'b0;
        end

        wait_drain();
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
